// ===== rtl/swm_pkg.sv =====
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding-window maximum filter.
// ----------------------------------------------------------------------------
`default_nettype none

package swm_pkg;

  // Width of the window length register
  localparam int unsigned CFG_W = 7;

  // Control that the top level broadcasts to every cell of the row
  typedef struct packed {
    logic shift;  // an item is accepted: every cell takes its neighbor's data
    logic clear;  // the item starts a new stream
  } cell_ctl_t;

  // Tag that travels down the pipeline next to the data of one item
  typedef struct packed {
    logic vld;    // this item yields a result
    logic last;   // this item is the last of its stream
  } pipe_tag_t;

endpackage : swm_pkg

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// ----------------------------------------------------------------------------
// swm_cell
// One candidate slot of the row. Cell AGE holds the sample that arrived AGE
// items ago, with a live bit that says it may still be the window maximum.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_cell #(
  parameter int unsigned W   = 16,
  parameter int unsigned KW  = 7,
  parameter int unsigned AGE = 0
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire swm_pkg::cell_ctl_t  ctl,
  input  wire logic [KW-1:0]       k,
  input  wire logic signed [W-1:0] new_sample,
  input  wire logic signed [W-1:0] prev_value,
  input  wire logic                prev_live,
  output logic signed [W-1:0]      value,
  output logic                     live
);

  import swm_pkg::*;

  logic signed [W-1:0] value_r;
  logic                live_r;
  logic                live_nxt;

  // Decide whether the entry coming from the neighbor stays a candidate
  generate
    if (AGE == 0) begin : g_head
      // insert slot: the new sample is always a candidate
      assign live_nxt = 1'b1;
    end else begin : g_body
      logic in_window;
      logic dominated;
      assign in_window = (KW'(AGE) < k);
      assign dominated = (prev_value <= new_sample);
      assign live_nxt  = prev_live && !ctl.clear && in_window && !dominated;
    end
  endgenerate

  // Hold the live bit; drop everything on reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= 1'b0;
    end else if (ctl.shift) begin
      live_r <= live_nxt;
    end
  end

  // Advance the value along the row
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      value_r <= prev_value;
    end
  end

  assign value = value_r;
  assign live  = live_r;

endmodule : swm_cell

`default_nettype wire

// ===== rtl/swm_max_tree.sv =====
// ----------------------------------------------------------------------------
// swm_max_tree
// Registered binary maximum tree over unsigned keys. Every tree level is one
// pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module swm_max_tree #(
  parameter int unsigned LEAVES = 64,
  parameter int unsigned W      = 16
) (
  input  wire logic         clk,
  input  wire logic         adv,
  input  wire logic [W-1:0] leaf_key [LEAVES],
  output logic [W-1:0]      root_key
);

  import swm_pkg::*;

  // Heap numbering: node 1 is the root, node i has children 2i and 2i+1
  logic [W-1:0] node_q [1:LEAVES-1];

  generate
    for (genvar i = 1; i < LEAVES; i++) begin : g_node
      logic [W-1:0] lft;
      logic [W-1:0] rgt;
      logic [W-1:0] nd_r;

      // Pick the children: leaves at the bottom level, nodes above it
      if (2 * i >= LEAVES) begin : g_leaf
        assign lft = leaf_key[2 * i - LEAVES];
        assign rgt = leaf_key[2 * i + 1 - LEAVES];
      end else begin : g_inner
        assign lft = node_q[2 * i];
        assign rgt = node_q[2 * i + 1];
      end

      // Keep the larger key
      always_ff @(posedge clk) begin
        if (adv) begin
          nd_r <= (lft >= rgt) ? lft : rgt;
        end
      end

      assign node_q[i] = nd_r;
    end
  endgenerate

  assign root_key = node_q[1];

endmodule : swm_max_tree

`default_nettype wire

// ===== rtl/sliding_window_maximum.sv =====
// ----------------------------------------------------------------------------
// sliding_window_maximum
// Streaming running-maximum filter over the last window_size samples.
// ----------------------------------------------------------------------------
// The block takes one sample per clock while the output is not stalled.
// Samples shift along a row of WINDOW_MAX cells; each cell keeps a live bit
// that is dropped once its sample leaves the window, is matched or beaten by
// a newer sample, or a new stream starts. A registered maximum tree then
// reduces the live cells, with every tree level registered, and each item's
// tag travels with its data. The rate is one item per cycle while no result
// is stalled, set by the shift of the cell row. No result is given until the
// stream has supplied window_size samples; a window_size of 0 acts as 1 and
// one above WINDOW_MAX acts as WINDOW_MAX. A stalled output holds the whole
// pipeline, so in_stall follows out_stall while a result waits. Write
// cfg_wr_data only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module sliding_window_maximum #(
  parameter int unsigned WINDOW_MAX   = 64,
  parameter int unsigned SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // configuration
  input  wire logic                           cfg_wr_en,
  input  wire logic [swm_pkg::CFG_W-1:0]      cfg_wr_data,
  // input items
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  wire logic                           in_first_of_stream,
  input  wire logic                           in_last_of_stream,
  // result items
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0]      out_window_max,
  output logic                                out_end_of_results
);

  import swm_pkg::*;

  localparam int unsigned W      = SAMPLE_WIDTH;
  localparam int unsigned KW     = $clog2(WINDOW_MAX + 1);
  localparam int unsigned LV     = $clog2(WINDOW_MAX);
  localparam int unsigned LEAVES = 1 << LV;

  logic [CFG_W-1:0]    window_size_r;
  logic [KW-1:0]       k;
  logic [KW-1:0]       seen_r;
  logic [KW-1:0]       seen_nxt;
  logic                adv;
  logic                accept;
  logic                emit;
  cell_ctl_t           ctl;
  pipe_tag_t           tag_r [LV+1];
  logic signed [W-1:0] cell_value [WINDOW_MAX];
  logic                cell_live  [WINDOW_MAX];
  logic [W-1:0]        leaf_key   [LEAVES];
  logic [W-1:0]        root_key;

  // Hold the window length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      window_size_r <= cfg_wr_data;
    end
  end

  // Clamp the window length to 1..WINDOW_MAX
  always_comb begin
    if (window_size_r == '0) begin
      k = KW'(1);
    end else if (32'(window_size_r) > 32'(WINDOW_MAX)) begin
      k = KW'(WINDOW_MAX);
    end else begin
      k = KW'(window_size_r);
    end
  end

  // Advance the pipeline unless a finished result is stalled
  assign adv       = !(tag_r[LV].vld && out_stall);
  assign in_stall  = !adv;
  assign accept    = in_valid && adv;
  assign ctl.shift = accept;
  assign ctl.clear = in_first_of_stream;

  // Count samples of the current stream, saturating at WINDOW_MAX
  always_comb begin
    if (in_first_of_stream) begin
      seen_nxt = KW'(1);
    end else if (seen_r == KW'(WINDOW_MAX)) begin
      seen_nxt = seen_r;
    end else begin
      seen_nxt = seen_r + KW'(1);
    end
  end

  assign emit = (seen_nxt >= k);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (accept) begin
      seen_r <= seen_nxt;
    end
  end

  // Row of candidate cells, youngest sample in cell 0
  generate
    for (genvar j = 0; j < WINDOW_MAX; j++) begin : g_cell
      logic signed [W-1:0] prev_value;
      logic                prev_live;

      if (j == 0) begin : g_first
        assign prev_value = in_sample;
        assign prev_live  = 1'b1;
      end else begin : g_rest
        assign prev_value = cell_value[j-1];
        assign prev_live  = cell_live[j-1];
      end

      swm_cell #(
        .W   (W),
        .KW  (KW),
        .AGE (j)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .k          (k),
        .new_sample (in_sample),
        .prev_value (prev_value),
        .prev_live  (prev_live),
        .value      (cell_value[j]),
        .live       (cell_live[j])
      );
    end
  endgenerate

  // Map live cells to order-preserving keys; dead and padding leaves sit lowest
  generate
    for (genvar j = 0; j < LEAVES; j++) begin : g_leaf
      if (j < WINDOW_MAX) begin : g_used
        assign leaf_key[j] = cell_live[j] ?
                             {~cell_value[j][W-1], cell_value[j][W-2:0]} : '0;
      end else begin : g_pad
        assign leaf_key[j] = '0;
      end
    end
  endgenerate

  swm_max_tree #(
    .LEAVES (LEAVES),
    .W      (W)
  ) u_tree (
    .clk      (clk),
    .adv      (adv),
    .leaf_key (leaf_key),
    .root_key (root_key)
  );

  // Carry each item's tag alongside its data through the row and the tree
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int unsigned n = 0; n <= LV; n++) begin
        tag_r[n] <= '0;
      end
    end else if (adv) begin
      tag_r[0].vld  <= accept && emit;
      tag_r[0].last <= in_last_of_stream;
      for (int unsigned n = 1; n <= LV; n++) begin
        tag_r[n] <= tag_r[n-1];
      end
    end
  end

  // Drive the result from the tree root
  assign out_valid          = tag_r[LV].vld;
  assign out_end_of_results = tag_r[LV].last;
  assign out_window_max     = {~root_key[W-1], root_key[W-2:0]};

endmodule : sliding_window_maximum

`default_nettype wire
